@@ design/bavg_pkg.sv @@
// ----------------------------------------------------------------------------
// bavg_pkg: shared types and constants for the box average decimator
// Sizes, register indexes and the job record that the front hands to the
// divider back end.
// ----------------------------------------------------------------------------
package bavg_pkg;

    localparam int MAX_WIDTH   = 4096;              // deepest row the line buffer holds
    localparam int MAX_FACTOR  = 256;               // largest bin
    localparam int COL_W       = $clog2(MAX_WIDTH);

    localparam int SAMPLE_W    = 24;
    localparam int FACTOR_W    = 9;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_FACTOR);

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // queue depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // divider retires DIV_BITS quotient bits per cycle, holding its last step while the result register is full
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int NUM_W       = DIV_STEPS * DIV_BITS;
    localparam int DIV_CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [CFG_INDEX_W-1:0] REG_AXIS         = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_FACTOR   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(3);

    localparam logic AXIS_ROW    = 1'b0;
    localparam logic AXIS_COLUMN = 1'b1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [FACTOR_W-1:0]     len;
        logic                    row_end;
        logic                    image_end;
    } job_t;

    typedef struct packed {
        logic full;
        logic almost_full;
    } q_status_t;

endpackage

@@ design/bavg_front.sv @@
// ----------------------------------------------------------------------------
// bavg_front: item intake, position tracking and bin summing
// Holds the registers, the row accumulator and the column-sum line buffer.
// Stage one accepts an item and reads the line buffer, stage two adds and
// writes back and pushes finished bins into the job queue.
// ----------------------------------------------------------------------------
module bavg_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bavg_pkg::SAMPLE_W-1:0]    s_tdata,
    input  bavg_pkg::q_status_t              q_status,
    output logic                             push_valid,
    output bavg_pkg::job_t                   push_job
);
    import bavg_pkg::*;

    // registers
    logic                axis_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // position and bin state
    logic [COL_W-1:0]        col_reg, col_next;
    logic [HEIGHT_W-1:0]     row_reg, row_next;
    logic [FACTOR_W-1:0]     fill_reg, fill_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;

    // stage two
    logic                    st2_valid_reg;
    logic                    st2_emit_reg;
    logic                    st2_mem_reg;
    logic                    st2_add_reg;
    logic                    st2_fwd_reg;
    logic [COL_W-1:0]        st2_idx_reg;
    logic signed [SUM_W-1:0] st2_base_reg;
    logic [FACTOR_W-1:0]     st2_len_reg;
    logic                    st2_row_end_reg;
    logic                    st2_image_end_reg;
    logic signed [SUM_W-1:0] rd_data_reg;
    logic signed [SUM_W-1:0] last_sum_reg;
    logic signed [SUM_W-1:0] st2_sum;

    logic signed [SUM_W-1:0] col_sums_mem [MAX_WIDTH];

    logic [FACTOR_W-1:0]     fac_eff;
    logic [WIDTH_W-1:0]      width_eff;
    logic [HEIGHT_W-1:0]     height_eff;
    logic [COL_W-1:0]        col_cur;
    logic [HEIGHT_W-1:0]     row_cur;
    logic                    last_col, last_row;
    logic [FACTOR_W:0]       fill_inc;
    logic                    bin_full;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] acc_sum;
    logic                    emit;
    logic                    cfg_hit;
    logic                    accept;

    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (cfg_index)
            REG_AXIS, REG_BIN_FACTOR, REG_ROW_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg   <= AXIS_ROW;
            factor_reg <= FACTOR_W'(1);
            width_reg  <= WIDTH_W'(MAX_WIDTH);
            height_reg <= HEIGHT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_AXIS:         axis_reg   <= cfg_data[0];
                REG_BIN_FACTOR:   factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_ROW_WIDTH:    width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp out-of-range register values
    always_comb begin
        priority if (factor_reg == '0)                  fac_eff = FACTOR_W'(1);
        else if (factor_reg > FACTOR_W'(MAX_FACTOR))    fac_eff = FACTOR_W'(MAX_FACTOR);
        else                                            fac_eff = factor_reg;
        priority if (width_reg == '0)                   width_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))       width_eff = WIDTH_W'(MAX_WIDTH);
        else                                            width_eff = width_reg;
        height_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign accept     = s_tvalid && s_tready;
    assign col_cur    = (WIDTH_W'(col_reg) >= width_eff) ? '0 : col_reg;
    assign row_cur    = (row_reg >= height_eff) ? '0 : row_reg;
    assign last_col   = (WIDTH_W'(col_cur) + WIDTH_W'(1) == width_eff);
    assign last_row   = ({1'b0, row_cur} + (HEIGHT_W+1)'(1) == {1'b0, height_eff});
    assign fill_inc   = {1'b0, fill_reg} + (FACTOR_W+1)'(1);
    assign bin_full   = (fill_inc >= {1'b0, fac_eff});
    assign sample_ext = SUM_W'(signed'(s_tdata));
    assign acc_sum    = acc_reg + sample_ext;
    assign emit       = (axis_reg == AXIS_COLUMN) ? (bin_full || last_row)
                                                  : (bin_full || last_col);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        fill_next = fill_reg;
        acc_next  = acc_reg;
        if (cfg_hit) begin
            col_next  = '0;
            row_next  = '0;
            fill_next = '0;
            acc_next  = '0;
        end else if (accept) begin
            if (axis_reg == AXIS_COLUMN) begin
                // vertical bins advance once per row
                if (last_col) begin
                    fill_next = emit ? '0 : fill_inc[FACTOR_W-1:0];
                end
            end else if (emit) begin
                acc_next  = '0;
                fill_next = '0;
            end else begin
                acc_next  = acc_sum;
                fill_next = fill_inc[FACTOR_W-1:0];
            end
            if (last_col) begin
                col_next = '0;
                if (last_row) begin
                    row_next  = '0;
                    fill_next = '0;
                    acc_next  = '0;
                end else begin
                    row_next = row_cur + HEIGHT_W'(1);
                end
            end else begin
                col_next = col_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            fill_reg      <= '0;
            acc_reg       <= '0;
            st2_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            fill_reg      <= fill_next;
            acc_reg       <= acc_next;
            st2_valid_reg <= accept;
        end
    end

    // stage two payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            st2_emit_reg      <= emit;
            st2_mem_reg       <= (axis_reg == AXIS_COLUMN);
            st2_add_reg       <= (axis_reg == AXIS_COLUMN) && (fill_reg != '0);
            // same column still being written back: take the sum from stage two
            st2_fwd_reg       <= st2_valid_reg && st2_mem_reg && (st2_idx_reg == col_cur);
            st2_idx_reg       <= col_cur;
            st2_base_reg      <= (axis_reg == AXIS_COLUMN) ? sample_ext : acc_sum;
            st2_len_reg       <= fill_inc[FACTOR_W-1:0];
            st2_row_end_reg   <= last_col;
            st2_image_end_reg <= last_col && last_row;
        end
        if (st2_valid_reg) begin
            last_sum_reg <= st2_sum;
        end
    end

    assign st2_sum = st2_add_reg ? ((st2_fwd_reg ? last_sum_reg : rd_data_reg) + st2_base_reg)
                                 : st2_base_reg;

    // line buffer
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= col_sums_mem[col_cur];
        end
        if (st2_valid_reg && st2_mem_reg) begin
            col_sums_mem[st2_idx_reg] <= st2_sum;
        end
    end

    // room for the item in stage two plus this one
    assign s_tready = st2_valid_reg ? !q_status.almost_full : !q_status.full;

    assign push_valid         = st2_valid_reg && st2_emit_reg;
    assign push_job.sum       = st2_sum;
    assign push_job.len       = st2_len_reg;
    assign push_job.row_end   = st2_row_end_reg;
    assign push_job.image_end = st2_image_end_reg;

endmodule

@@ design/bavg_queue.sv @@
// ----------------------------------------------------------------------------
// bavg_queue: short job queue between front and divider
// Circular buffer of finished bins; reports full and almost full.
// ----------------------------------------------------------------------------
module bavg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  bavg_pkg::job_t      push_job,
    output bavg_pkg::q_status_t q_status,
    output logic                pop_valid,
    input  logic                pop,
    output bavg_pkg::job_t      pop_job
);
    import bavg_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid && !do_pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (!push_valid && do_pop) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign q_status.full        = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.almost_full = (count_reg >= (QPTR_W+1)'(QUEUE_DEPTH - 1));
    assign pop_valid            = (count_reg != '0);
    assign pop_job              = slot_reg[rd_ptr_reg];

endmodule

@@ design/bavg_back.sv @@
// ----------------------------------------------------------------------------
// bavg_back: bin divider and result register
// Signed sum over bin length, truncated toward zero, by a radix-16
// restoring divider; the result register feeds the master side.
// ----------------------------------------------------------------------------
module bavg_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    input  bavg_pkg::job_t                pop_job,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bavg_pkg::SAMPLE_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import bavg_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [FACTOR_W-1:0]  rem_reg;
    logic [FACTOR_W-1:0]  div_reg;
    logic                 neg_reg;
    logic                 row_end_reg;
    logic                 image_end_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_data_reg;
    logic                 out_last_reg;
    logic                 out_user_reg;

    logic [NUM_W-1:0]     num_step;
    logic [FACTOR_W-1:0]  rem_step;
    logic [NUM_W-1:0]     quot_signed;
    logic signed [NUM_W-1:0] sum_ext;
    logic                 last_step;
    logic                 out_free;
    logic                 advance;
    logic                 finish;

    // one radix-16 step: four compare-subtracts on the narrow remainder
    always_comb begin
        logic [FACTOR_W:0]   trial;
        logic [FACTOR_W-1:0] rem;
        logic [DIV_BITS-1:0] qbits;
        rem   = rem_reg;
        qbits = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {rem, num_reg[NUM_W-1-k]};
            if (trial >= {1'b0, div_reg}) begin
                rem                  = FACTOR_W'(trial - {1'b0, div_reg});
                qbits[DIV_BITS-1-k] = 1'b1;
            end else begin
                rem = trial[FACTOR_W-1:0];
            end
        end
        rem_step = rem;
        num_step = {num_reg[NUM_W-DIV_BITS-1:0], qbits};
    end

    assign quot_signed = neg_reg ? (NUM_W'(0) - num_step) : num_step;
    assign sum_ext     = NUM_W'(pop_job.sum);
    assign last_step   = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign out_free    = !out_valid_reg || m_tready;
    assign advance     = busy_reg && (!last_step || out_free);
    assign finish      = advance && last_step;
    assign pop         = !busy_reg && pop_valid;

    always_comb begin
        busy_next = busy_reg;
        if (pop) begin
            busy_next = 1'b1;
        end else if (finish) begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            neg_reg       <= pop_job.sum[SUM_W-1];
            num_reg       <= pop_job.sum[SUM_W-1] ? (NUM_W'(0) - sum_ext) : sum_ext;
            rem_reg       <= '0;
            div_reg       <= pop_job.len;
            cnt_reg       <= '0;
            row_end_reg   <= pop_job.row_end;
            image_end_reg <= pop_job.image_end;
        end else if (advance) begin
            num_reg <= num_step;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        if (finish) begin
            out_data_reg <= quot_signed[SAMPLE_W-1:0];
            out_last_reg <= row_end_reg;
            out_user_reg <= image_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ design/box_average_decimator_core.sv @@
// ----------------------------------------------------------------------------
// box_average_decimator_core: box-filter decimator for row-major samples
// Averages non-overlapping bins along a row or across rows (line buffer of
// column sums), with short bins at row and image end divided by true length.
//
//   channel   direction  handshake           payload
//   s_        in         s_tvalid/s_tready   tdata = sample
//   m_        out        m_tvalid/m_tready   tdata = average, tlast = row end,
//                                            tuser = image end
//   cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Front takes one item per cycle while the job queue has room; the item's
// sum is pushed into the job queue from stage two (line buffer read at the
// accepting edge, add and write back in the next cycle).
// The shared divider takes a new bin only once it is through with the last
// one, so for short bins the divider sets the sustained rate.
// Synchronous active-low reset; no clearing pass, since a column sum is
// always written in the first row of its bin before it is read.
// Master-side stalls back up through the result register, the divider and
// the queue; the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module box_average_decimator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes; index 0 axis, 1 bin_factor, 2 row_width, 3 image_height
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]  cfg_data,
    // sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bavg_pkg::SAMPLE_W-1:0]    s_tdata,   // [23:0] sample
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bavg_pkg::SAMPLE_W-1:0]    m_tdata,   // [23:0] average
    output logic                             m_tlast,   // row end
    output logic                             m_tuser    // [0] image end
);
    import bavg_pkg::*;

    // front to queue
    logic      push_valid;
    job_t      push_job;
    q_status_t q_status;

    // queue to divider
    logic      pop_valid;
    logic      pop;
    job_t      pop_job;

    // intake, positions, accumulators and line buffer
    bavg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    // finished bins waiting for the divider
    bavg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_status   (q_status),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    // divide and present
    bavg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for box_average_decimator_core
// A short table of directed items covers the field extremes, both binning
// directions, short bins at row and image end, out-of-range register values
// and ignored register indexes. Random images with random register settings
// follow. Every item is run through a behavioral model of the binning.
// Each result leaving the core is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import bavg_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 32;     // front, queue and divider empty out
    localparam int TAIL_CYCLES   = 64;
    localparam int RANDOM_ITEMS  = 900;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_INDEX_W-1:0] NO_INDEX  = '0;
    localparam logic [CFG_INDEX_W-1:0] BAD_INDEX = '1;   // beyond the register list

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                row_end;
        logic                image_end;
    } avg_result_t;

    typedef enum logic [1:0] {
        STEP_WRITE,     // register write, index and value
        STEP_SAMPLE,    // item, result taken from the model
        STEP_KNOWN      // item, result typed in below
    } step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [SAMPLE_W-1:0] value;
        avg_result_t         want;
    } step_t;

    localparam avg_result_t NONE = '0;

    // After reset: bins along rows, factor 1, rows of 4096, one-row image.
    localparam step_t DIRECTED [39] = '{
        '{STEP_KNOWN,  NO_INDEX,         24'h7FFFFF, '{24'h7FFFFF, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'h800000, '{24'h800000, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'h000000, '{24'h000000, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'hFFFFFF, '{24'hFFFFFF, 1'b0, 1'b0}},
        // 3x2 image, pairs along the row; odd column closes a short bin
        '{STEP_WRITE,  REG_AXIS,         24'(AXIS_ROW), NONE},
        '{STEP_WRITE,  REG_BIN_FACTOR,   24'd2,      NONE},
        '{STEP_WRITE,  REG_ROW_WIDTH,    24'd3,      NONE},
        '{STEP_WRITE,  REG_IMAGE_HEIGHT, 24'd2,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'h7FFFFF, NONE},
        '{STEP_KNOWN,  NO_INDEX,         24'h7FFFFF, '{24'h7FFFFF, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'h000005, '{24'h000005, 1'b1, 1'b0}},
        '{STEP_SAMPLE, NO_INDEX,         24'hFFFFFD, NONE},
        // -7 / 2 truncates toward zero
        '{STEP_KNOWN,  NO_INDEX,         24'hFFFFFC, '{24'hFFFFFD, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'h800000, '{24'h800000, 1'b1, 1'b1}},
        // vertical bins of 3 cut to 2 by the image end
        '{STEP_WRITE,  REG_AXIS,         24'(AXIS_COLUMN), NONE},
        '{STEP_WRITE,  REG_BIN_FACTOR,   24'd3,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd1,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd2,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd3,      NONE},
        // unknown index: no restart, open column sums survive
        '{STEP_WRITE,  BAD_INDEX,        24'hFFFF,   NONE},
        '{STEP_KNOWN,  NO_INDEX,         24'd4,      '{24'd2, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'd5,      '{24'd3, 1'b0, 1'b0}},
        '{STEP_KNOWN,  NO_INDEX,         24'd6,      '{24'd4, 1'b1, 1'b1}},
        // zero factor, width and height all act as 1: every item is an image
        '{STEP_WRITE,  REG_BIN_FACTOR,   24'd0,      NONE},
        '{STEP_WRITE,  REG_ROW_WIDTH,    24'd0,      NONE},
        '{STEP_WRITE,  REG_IMAGE_HEIGHT, 24'd0,      NONE},
        '{STEP_KNOWN,  NO_INDEX,         24'h123456, '{24'h123456, 1'b1, 1'b1}},
        '{STEP_KNOWN,  NO_INDEX,         24'hEDCBA9, '{24'hEDCBA9, 1'b1, 1'b1}},
        '{STEP_WRITE,  REG_AXIS,         24'(AXIS_ROW), NONE},
        '{STEP_KNOWN,  NO_INDEX,         24'h000001, '{24'h000001, 1'b1, 1'b1}},
        // a valid write mid-bin drops the open bin
        '{STEP_WRITE,  REG_ROW_WIDTH,    24'd4,      NONE},
        '{STEP_WRITE,  REG_BIN_FACTOR,   24'd4,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd10,     NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd20,     NONE},
        '{STEP_WRITE,  REG_IMAGE_HEIGHT, 24'd1,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd1,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd2,      NONE},
        '{STEP_SAMPLE, NO_INDEX,         24'd3,      NONE},
        '{STEP_KNOWN,  NO_INDEX,         24'd6,      '{24'd3, 1'b1, 1'b1}}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // model of the register file and binning state
    logic                cfg_axis   = AXIS_ROW;
    logic [FACTOR_W-1:0] cfg_factor = FACTOR_W'(1);
    logic [WIDTH_W-1:0]  cfg_width  = WIDTH_W'(MAX_WIDTH);
    logic [HEIGHT_W-1:0] cfg_height = HEIGHT_W'(1);
    int unsigned         col_pos    = 0;
    int unsigned         row_pos    = 0;
    int unsigned         bin_fill   = 0;
    longint              row_sum    = 0;
    longint              col_sums [MAX_WIDTH];

    avg_result_t pending_averages [$];
    int          bad_results   = 0;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    box_average_decimator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned eff_factor();
        if (cfg_factor == 0) return 1;
        return (cfg_factor > MAX_FACTOR) ? MAX_FACTOR : cfg_factor;
    endfunction

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic void note_write(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_AXIS:         cfg_axis   = data[0];
            REG_BIN_FACTOR:   cfg_factor = data[FACTOR_W-1:0];
            REG_ROW_WIDTH:    cfg_width  = data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
            default:          return;
        endcase
        col_pos  = 0;
        row_pos  = 0;
        bin_fill = 0;
        row_sum  = 0;
    endfunction

    // Advances the binning state by one item; returns 1 when a bin closes.
    function automatic bit bin_sample(input logic [SAMPLE_W-1:0] smp,
                                      output avg_result_t res);
        int unsigned fac, w, h, col, row;
        bit          last_col, last_row, emit, closes;
        longint      s, sum, quo;
        fac  = eff_factor();
        w    = eff_width();
        h    = eff_height();
        s    = longint'($signed(smp));
        emit = 1'b0;
        quo  = 0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        col      = col_pos;
        row      = row_pos;
        last_col = (col + 1 == w);
        last_row = (row + 1 == h);
        if (cfg_axis == AXIS_ROW) begin
            row_sum += s;
            bin_fill++;
            if (bin_fill >= fac || last_col) begin
                quo      = row_sum / longint'(bin_fill);
                emit     = 1'b1;
                row_sum  = 0;
                bin_fill = 0;
            end
        end else begin
            // first row of a vertical bin overwrites the column sum
            sum           = (bin_fill == 0) ? s : col_sums[col] + s;
            col_sums[col] = sum;
            closes        = (bin_fill + 1 >= fac) || last_row;
            if (closes) begin
                quo  = sum / longint'(bin_fill + 1);
                emit = 1'b1;
            end
            if (last_col) bin_fill = closes ? 0 : bin_fill + 1;
        end
        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos  = 0;
                bin_fill = 0;
                row_sum  = 0;
            end else begin
                row_pos = row + 1;
            end
        end else begin
            col_pos = col + 1;
        end
        res.average   = quo[SAMPLE_W-1:0];
        res.row_end   = last_col;
        res.image_end = last_col && last_row;
        return emit;
    endfunction

    task automatic hold_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Register writes go in only once all results are out and the core is quiet.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        note_write(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Returns right after the accepting edge; valid stays up for a following item.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit known,
                               input avg_result_t want);
        avg_result_t got;
        bit          emit;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        emit = bin_sample(smp, got);
        if (known) pending_averages.push_back(want);
        else if (emit) pending_averages.push_back(got);
    endtask

    // One random register setting, then mostly whole images with random content;
    // some phases stop mid-image so the next write restarts a partial one.
    task automatic run_image_phase(inout int sent);
        logic [CFG_DATA_W-1:0] val;
        logic [SAMPLE_W-1:0]   smp;
        int unsigned           w, h, size, n, pause_at;
        if ($urandom_range(0, 3) != 0) write_reg(REG_AXIS, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = CFG_DATA_W'(MAX_FACTOR);
                2:       val = CFG_DATA_W'($urandom);
                default: val = CFG_DATA_W'($urandom_range(1, 6));
            endcase
            write_reg(REG_BIN_FACTOR, val);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = CFG_DATA_W'($urandom_range(11, 48));
                default: val = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            write_reg(REG_ROW_WIDTH, val);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = CFG_DATA_W'($urandom);
                default: val = CFG_DATA_W'($urandom_range(1, 5));
            endcase
            write_reg(REG_IMAGE_HEIGHT, val);
        end
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));

        w    = eff_width();
        h    = eff_height();
        size = w * h;
        n    = (size <= 48) ? size * $urandom_range(1, 3) : $urandom_range(16, 64);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w);
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;

        for (int unsigned i = 0; i < n; i++) begin
            if (i == pause_at) begin
                // sender holds off until the core has delivered everything
                hold_input();
                while (pending_averages.size() != 0) @(posedge aclk);
            end
            case ($urandom_range(0, 7))
                0:       smp = 24'h7FFFFF;
                1:       smp = 24'h800000;
                2:       smp = SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
                default: smp = SAMPLE_W'($urandom);
            endcase
            send_sample(smp, 1'b0, NONE);
        end
        hold_input();
        sent += n;
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge aclk) begin : check_results
        avg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_averages.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT)
                    $display("tb_top: unexpected result avg %h row_end %b image_end %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_averages.pop_front();
                if (m_tdata !== want.average || m_tlast !== want.row_end ||
                    m_tuser !== want.image_end) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                        $display("tb_top: mismatch avg %h/%h row_end %b/%b image_end %b/%b",
                                 want.average, m_tdata, want.row_end, m_tlast,
                                 want.image_end, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        foreach (col_sums[i]) col_sums[i] = 0;
        send_idle_pct = 17;
        recv_idle_pct = 60;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].kind)
                STEP_WRITE: begin
                    hold_input();
                    write_reg(DIRECTED[i].index, DIRECTED[i].value[CFG_DATA_W-1:0]);
                end
                STEP_SAMPLE: send_sample(DIRECTED[i].value, 1'b0, NONE);
                default:     send_sample(DIRECTED[i].value, 1'b1, DIRECTED[i].want);
            endcase
        end
        hold_input();

        // sender-light / receiver-heavy, then reversed, then no idling at all
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 60 : 0;
            recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 17 : 0;
            if (mode == 2) begin
                // all-ones register values: factor and width saturate; one full bin
                write_reg(REG_AXIS, CFG_DATA_W'(AXIS_ROW));
                write_reg(REG_BIN_FACTOR, '1);
                write_reg(REG_ROW_WIDTH, '1);
                write_reg(REG_IMAGE_HEIGHT, '1);
                repeat (MAX_FACTOR) send_sample(SAMPLE_W'($urandom), 1'b0, NONE);
                hold_input();
                write_reg(REG_ROW_WIDTH, CFG_DATA_W'(8));
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) run_image_phase(sent);
        end

        hold_input();
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (bad_results == 0 && pending_averages.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
